@@ hdl/psc_pkg.sv @@
// ============================================================================
// psc_pkg: shared definitions for the palindromic substring counter
// Field widths, the saturation limit of the running count and the result type.
// ============================================================================
package psc_pkg;

	// Width of one string byte.
	localparam int unsigned SYM_W = 8;

	// Width of the palindrome count and its saturation value.
	localparam int unsigned TOTAL_W = 16;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// One result transfer: the count and the too-long flag.
	typedef struct packed {
		logic               too_long;
		logic [TOTAL_W-1:0] total_palindromes;
	} psc_result_t;

endpackage : psc_pkg

@@ hdl/psc_ram.sv @@
// ============================================================================
// psc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module psc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule : psc_ram

@@ hdl/palindromic_substring_counter_top.sv @@
// ============================================================================
// palindromic_substring_counter_top: counts palindromic substrings of a string
// Bytes arrive one per transfer; the transfer with tlast returns the number of
// palindromic substrings of the whole string (every occurrence counted) and a
// flag set when the string ran past MAX_LEN bytes.
// ============================================================================
//
//  Channel  Dir  tdata                     tuser       tlast
//  s_axis   in   [7:0] symbol              -           last_symbol
//  m_axis   out  [15:0] total_palindromes  [0] too_long  -
//
//  A byte at position p (from 0) is accepted, then the candidate lengths from
//  p+1 down to one are scanned one per cycle through the byte RAM and the
//  mask RAM, then the read pipeline drains. A byte beyond MAX_LEN is not
//  stored or scanned. After the last byte the result register is loaded; it
//  waits there if m_axis stalls while the next string is already being accepted.
//  Reset clears the counters only; no RAM clearing pass is needed, since a
//  string only reads entries it has written itself.
// ============================================================================
module palindromic_substring_counter_top #(
	parameter int unsigned MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input byte stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // last_symbol
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] total_palindromes
	output logic [0:0]  m_axis_tuser    // [0] too_long
);

	import psc_pkg::*;

	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] LEN_MAX = PW'(MAX_LEN);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [PW-1:0]      bytes_seen_q;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      len_q;
	logic [SYM_W-1:0]   sym_q;
	logic               last_q;
	logic [TOTAL_W-1:0] total_q;
	logic               overflow_q;
	logic               vld_s1;
	logic [PW-1:0]      len_s1;
	psc_result_t        result_q;
	logic               out_valid_q;

	logic               in_xfer;
	logic               out_xfer;
	logic               in_range;
	logic               byte_wr_en;
	logic [AW-1:0]      byte_rd_addr;
	logic [AW-1:0]      mask_rd_addr;
	logic [AW-1:0]      mask_wr_addr;
	logic [SYM_W-1:0]   byte_rd_data;
	logic [0:0]         mask_rd_data;
	logic               ends_c;
	logic               out_free;

	// Handshakes.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = out_valid_q && m_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign in_range      = (bytes_seen_q < LEN_MAX);

	// Byte RAM: the string is stored at its own positions.
	assign byte_wr_en   = in_xfer && in_range;
	assign byte_rd_addr = AW'(pos_q - len_q + PW'(1));

	psc_ram #(
		.WIDTH (SYM_W),
		.DEPTH (MAX_LEN)
	) u_byte_ram (
		.clk     (clk),
		.wr_en   (byte_wr_en),
		.wr_addr (bytes_seen_q[AW-1:0]),
		.wr_data (s_axis_tdata),
		.rd_addr (byte_rd_addr),
		.rd_data (byte_rd_data)
	);

	// Mask RAM: entry L-1 is set when a palindrome of length L ends at the
	// newest byte. Lengths are scanned downward, so entry L-3 is read before
	// the current byte rewrites it.
	assign mask_rd_addr = AW'(len_q - PW'(3));
	assign mask_wr_addr = AW'(len_s1 - PW'(1));

	psc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_LEN)
	) u_mask_ram (
		.clk     (clk),
		.wr_en   (vld_s1),
		.wr_addr (mask_wr_addr),
		.wr_data (ends_c),
		.rd_addr (mask_rd_addr),
		.rd_data (mask_rd_data)
	);

	// Does a palindrome of length len_s1 end at the current byte?
	always_comb begin
		if (len_s1 == PW'(1)) begin
			ends_c = 1'b1;
		end else if (len_s1 == PW'(2)) begin
			ends_c = (sym_q == byte_rd_data);
		end else begin
			ends_c = (sym_q == byte_rd_data) && mask_rd_data[0];
		end
	end

	// Sequencer, counters and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bytes_seen_q <= '0;
			pos_q        <= '0;
			len_q        <= '0;
			sym_q        <= '0;
			last_q       <= 1'b0;
			total_q      <= '0;
			overflow_q   <= 1'b0;
			vld_s1       <= 1'b0;
			len_s1       <= '0;
			result_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// Result register empties on its transfer.
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end

			// Compare stage: one length per cycle, saturating count.
			vld_s1 <= 1'b0;
			if (vld_s1 && ends_c && (total_q != TOTAL_MAX)) begin
				total_q <= total_q + TOTAL_W'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						sym_q  <= s_axis_tdata;
						last_q <= s_axis_tlast;
						if (in_range) begin
							pos_q        <= bytes_seen_q;
							len_q        <= bytes_seen_q + PW'(1);
							bytes_seen_q <= bytes_seen_q + PW'(1);
							state_q      <= ST_SCAN;
						end else begin
							overflow_q <= 1'b1;
							if (s_axis_tlast) begin
								state_q <= ST_FINISH;
							end
						end
					end
				end
				ST_SCAN: begin
					vld_s1 <= 1'b1;
					len_s1 <= len_q;
					len_q  <= len_q - PW'(1);
					if (len_q == PW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= last_q ? ST_FINISH : ST_IDLE;
				end
				ST_FINISH: begin
					if (out_free) begin
						result_q.total_palindromes <= total_q;
						result_q.too_long          <= overflow_q;
						out_valid_q                <= 1'b1;
						bytes_seen_q               <= '0;
						total_q                    <= '0;
						overflow_q                 <= 1'b0;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output port.
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = result_q.total_palindromes;
	assign m_axis_tuser[0] = result_q.too_long;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// The byte counter never passes the string limit.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= LEN_MAX)
		else $error("bytes_seen exceeds MAX_LEN");

	// Scanned lengths stay between one and the byte's position plus one.
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (len_q != '0) && (len_q <= pos_q + PW'(1)))
		else $error("scan length out of range");

	// The compare stage is empty whenever a new byte can be taken.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !vld_s1)
		else $error("compare stage busy while idle");

	// The result is loaded only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_valid_q && !m_axis_tready |=>
			(state_q == ST_FINISH))
		else $error("result register overwritten");

	// After a result the counters start over.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_free |=>
			(bytes_seen_q == '0) && (total_q == '0) && !overflow_q)
		else $error("state not cleared after result");

endmodule : palindromic_substring_counter_top

@@ test/palindrome_count_checker.sv @@
// ============================================================================
// palindrome_count_checker: scoreboard for the palindromic substring counter
// Watches both stream channels, works out the count of palindromic substrings
// for every string it sees go in, and compares each result transfer with the
// oldest count still awaited.
// ============================================================================
module palindrome_count_checker #(
	parameter int unsigned MAX_LEN = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // last_symbol
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [15:0] total_palindromes
	input  logic [0:0]  m_axis_tuser,   // [0] too_long
	output int          mismatches,
	output int          counts_awaited
);

	timeunit 1ns;
	timeprecision 1ps;

	import psc_pkg::*;

	// Shadow state of the string in progress.
	logic [7:0]  history_bytes [MAX_LEN-1];   // newest byte at index 0
	bit          tail_pal      [MAX_LEN];     // entry L-1: length L ends at previous byte
	int unsigned bytes_taken;
	int unsigned tally;
	bit          overran;

	psc_result_t expected_counts [$];
	psc_result_t want;
	int unsigned hits;
	int unsigned sum;

	// Return to the empty-string state.
	function automatic void clear_string();
		foreach (history_bytes[i]) history_bytes[i] = '0;
		foreach (tail_pal[i]) tail_pal[i] = 1'b0;
		bytes_taken = 0;
		tally       = 0;
		overran     = 1'b0;
	endfunction

	// Take one byte into the string and return how many palindromes end at it.
	function automatic int unsigned absorb_byte(input logic [7:0] sym);
		int unsigned found;
		bit          ends;
		found = 0;
		// Longest length first, so the entry for L-2 is read before it is rewritten.
		for (int len = MAX_LEN; len >= 1; len--) begin
			ends = 1'b0;
			if (len <= int'(bytes_taken) + 1) begin
				if (len == 1)
					ends = 1'b1;
				else if (len == 2)
					ends = (sym == history_bytes[0]);
				else
					ends = (sym == history_bytes[len-2]) && tail_pal[len-3];
			end
			tail_pal[len-1] = ends;
			if (ends)
				found++;
		end
		for (int k = MAX_LEN - 2; k >= 1; k--)
			history_bytes[k] = history_bytes[k-1];
		history_bytes[0] = sym;
		bytes_taken++;
		return found;
	endfunction

	// Compare result transfers first, then fold in the byte of this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
			expected_counts.delete();
			mismatches     = 0;
			counts_awaited = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: result with no count awaited: total %0d, too_long %0b",
						$time, m_axis_tdata, m_axis_tuser[0]);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					if (m_axis_tdata !== want.total_palindromes) begin
						$display("%0t: total_palindromes expected %0d, got %0d",
							$time, want.total_palindromes, m_axis_tdata);
						mismatches++;
					end
					if (m_axis_tuser[0] !== want.too_long) begin
						$display("%0t: too_long expected %0b, got %0b",
							$time, want.too_long, m_axis_tuser[0]);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				// Bytes past the length limit only mark the string as too long.
				if (bytes_taken < MAX_LEN) begin
					hits  = absorb_byte(s_axis_tdata);
					sum   = tally + hits;
					tally = (sum > TOTAL_MAX) ? TOTAL_MAX : sum;
				end else begin
					overran = 1'b1;
				end
				if (s_axis_tlast) begin
					want.total_palindromes = tally[TOTAL_W-1:0];
					want.too_long          = overran;
					expected_counts.push_back(want);
					clear_string();
				end
			end
			counts_awaited = expected_counts.size();
		end
	end

endmodule : palindrome_count_checker

@@ test/testbench.sv @@
// ============================================================================
// testbench: stimulus and verdict for the palindromic substring counter
// Sends short directed strings, then random strings of several shapes (two
// letter, mirrored, constant, noise) with a few strings at and past the length
// limit; both channels stall at random outside one stretch. The checker scores the results.
// ============================================================================
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import psc_pkg::*;

	localparam int unsigned PSC_MAX_LEN = 256;
	localparam int          HALF_PERIOD = 2;
	localparam int          IDLE_PCT    = 24;
	localparam int          DRAIN_CYCLES = PSC_MAX_LEN + 64;
	localparam longint      TIMEOUT_NS  = 8_000_000;

	typedef enum int {
		STR_PAIR,
		STR_MIRROR,
		STR_SAME,
		STR_NOISE
	} string_kind_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	int mismatches;
	int counts_awaited;
	int items_sent = 0;
	bit idling_on  = 1'b1;

	always #HALF_PERIOD clk = ~clk;

	palindromic_substring_counter_top #(
		.MAX_LEN(PSC_MAX_LEN)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	palindrome_count_checker #(
		.MAX_LEN(PSC_MAX_LEN)
	) scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.counts_awaited(counts_awaited)
	);

	// The result side stalls at random while idling is enabled.
	always @(negedge clk) begin
		if (idling_on)
			m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
		else
			m_axis_tready <= 1'b1;
	end

	// Present one byte at a falling edge and hold it until the transfer.
	task automatic send_byte(input logic [7:0] sym, input logic last);
		while (idling_on && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// Build a string of the given shape and send it, tlast on its final byte.
	task automatic run_string(input int len, input string_kind_t kind);
		logic [7:0] chars [$];
		logic [7:0] base;
		base = 8'($urandom_range(255));
		for (int i = 0; i < len; i++) begin
			case (kind)
				STR_PAIR: begin
					chars.push_back(base ^ 8'($urandom_range(1)));
				end
				STR_MIRROR: begin
					if (i < (len + 1) / 2)
						chars.push_back(base ^ 8'($urandom_range(3)));
					else
						chars.push_back(chars[len-1-i]);
				end
				STR_SAME: begin
					chars.push_back(base);
				end
				default: begin
					chars.push_back(8'($urandom_range(255)));
				end
			endcase
		end
		foreach (chars[i])
			send_byte(chars[i], i == chars.size() - 1);
	endtask

	// Short strings of random shape until the item count reaches the mark.
	task automatic short_strings(input int mark);
		int len;
		while (items_sent < mark) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			run_string(len, string_kind_t'($urandom_range(3)));
		end
	endtask

	// Main sequence: reset, directed strings, random phases, then the verdict.
	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A single byte, and the lowest symbol.
		send_byte(8'h00, 1'b1);
		// Two equal top-value bytes.
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// Odd palindrome built from both extremes.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		// Two bytes that differ in every bit.
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		// Constant run: every substring is a palindrome.
		for (int i = 0; i < 5; i++)
			send_byte(8'h03, i == 4);
		// Odd palindrome with distinct inner bytes.
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h01, 1'b1);
		// Even palindrome.
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b1);

		// Random strings with both sides stalling, then a full-length constant string.
		short_strings(300);
		run_string(PSC_MAX_LEN, STR_SAME);

		// A stretch with no idling, ending in a string that runs past the limit.
		idling_on <= 1'b0;
		short_strings(650);
		run_string(PSC_MAX_LEN + 5, STR_PAIR);
		idling_on <= 1'b1;

		// Only the final byte lies past the limit.
		run_string(PSC_MAX_LEN + 1, STR_MIRROR);
		short_strings(1250);
		s_axis_tvalid <= 1'b0;

		// Wait for every count, then watch for stray results.
		while (counts_awaited != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && counts_awaited == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule : testbench

@@ files.f @@
hdl/psc_pkg.sv
hdl/psc_ram.sv
hdl/palindromic_substring_counter_top.sv
test/palindrome_count_checker.sv
test/testbench.sv
